// ===== src/aces_fitted_tone_map_top_defines.svh =====
// Assertion macros for the ACES fitted tone map checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ACES_FITTED_TONE_MAP_TOP_DEFINES_SVH
`define ACES_FITTED_TONE_MAP_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define AFTM_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Implication after a fixed number of cycles, disabled during reset
`define AFTM_ASSERT_DLY(label, pre, n, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> ##n (post)) \
    else $error(msg);

`endif

// ===== src/aftm_pkg.sv =====
// Shared constants, coefficient rows and curve tables of the ACES fitted tone map.
// No dependencies; every module file imports this package (the macros header does not).
package aftm_pkg;

  localparam int IQ                 = 20;
  localparam int FRAC_BITS_DEF      = 16;
  localparam int INPUT_INT_BITS_DEF = 8;
  localparam int TW                 = IQ + 1;   // table entry / input coefficient width
  localparam int QW                 = IQ + 1;   // fit quotient width

  // pipeline depth of each lane
  localparam int ENC_STAGES     = 10;
  localparam int FIT_PRE_STAGES = 4;
  localparam int OUT_STAGES     = 5;
  localparam int LATENCY        = ENC_STAGES + FIT_PRE_STAGES + QW + OUT_STAGES;

  // sRGB encode curve
  localparam int SMALL_X_LIM = 3283;
  localparam int ENC_SLOPE   = 13547602;
  localparam int ENC_GAIN    = 1106248;
  localparam int ENC_OFFSET  = 57672;
  localparam int KK_OFS      = 52;
  localparam int RECIP12     = 171;
  localparam int RECIP12_SH  = 11;
  localparam int OCT_LEN     = 12;

  // sRGB decode curve
  localparam int DEC_LIM   = 42415;
  localparam int DEC_SLOPE = 81159;

  // rational fit
  localparam int FIT_A  = 25773;
  localparam int FIT_C  = 95;
  localparam int FIT_B2 = 1031515;
  localparam int FIT_B1 = 453982;
  localparam int FIT_B0 = 249646;

  typedef logic [2:0][TW-1:0]   urow_t;
  typedef logic [2:0][TW:0]     srow_t;
  typedef logic [11:0][TW-1:0]  oct_tab_t;
  typedef logic [32:0][TW-1:0]  mant_tab_t;
  typedef logic [256:0][TW-1:0] dec_tab_t;

  // width of an encoded channel for a given input integer width
  function automatic int enc_width(input int int_bits);
    int xw;
    int kkmax;
    xw    = int_bits + IQ;
    kkmax = 5 * (xw - 1) - KK_OFS;
    return IQ + 2 + kkmax / 12 - 4 + 1;
  endfunction

  function automatic logic [63:0] mulq(input logic [63:0] a, input logic [63:0] b);
    return (a * b) >> IQ;
  endfunction

  function automatic logic [63:0] pow12(input logic [63:0] y);
    logic [63:0] y2;
    logic [63:0] y4;
    logic [63:0] y8;
    y2 = mulq(y, y);
    y4 = mulq(y2, y2);
    y8 = mulq(y4, y4);
    return mulq(y8, y4);
  endfunction

  function automatic logic [63:0] pow5(input logic [63:0] y);
    logic [63:0] y2;
    logic [63:0] y4;
    y2 = mulq(y, y);
    y4 = mulq(y2, y2);
    return mulq(y4, y);
  endfunction

  // largest y below 2^21 with y^12 <= target
  function automatic logic [63:0] root12(input logic [63:0] target);
    logic [63:0] y;
    logic [63:0] c;
    y = '0;
    for (int b = IQ; b >= 0; b--) begin
      c = y | (64'd1 << b);
      if (pow12(c) <= target) y = c;
    end
    return y;
  endfunction

  // largest y below 2^21 with y^5 <= target
  function automatic logic [63:0] root5(input logic [63:0] target);
    logic [63:0] y;
    logic [63:0] c;
    y = '0;
    for (int b = IQ; b >= 0; b--) begin
      c = y | (64'd1 << b);
      if (pow5(c) <= target) y = c;
    end
    return y;
  endfunction

  function automatic oct_tab_t build_oct();
    oct_tab_t t;
    for (int i = 0; i < OCT_LEN; i++) t[i] = TW'(root12(64'd1 << (IQ + i)));
    return t;
  endfunction

  function automatic mant_tab_t build_mant();
    mant_tab_t t;
    for (int i = 0; i < 33; i++)
      t[i] = TW'(root12(pow5((64'd1 << IQ) + (64'(i) << (IQ - 5)))));
    return t;
  endfunction

  function automatic dec_tab_t build_dec();
    dec_tab_t    t;
    logic [63:0] x;
    logic [63:0] u;
    logic [63:0] u2;
    for (int i = 0; i < 257; i++) begin
      x    = 64'(i) << (IQ - 8);
      u    = ((x + 64'(ENC_OFFSET)) << IQ) / ENC_GAIN;
      u2   = mulq(u, u);
      t[i] = TW'(mulq(u2, root5(u2)));
    end
    return t;
  endfunction

  localparam oct_tab_t  OCT_TAB  = build_oct();
  localparam mant_tab_t MANT_TAB = build_mant();
  localparam dec_tab_t  DEC_TAB  = build_dec();

  // input matrix rows (Q.20)
  function automatic urow_t mat_in_row(input int i);
    urow_t r;
    unique case (i)
      0:       r = {21'd50573,  21'd371804, 21'd626199};
      1:       r = {21'd16421,  21'd952464, 21'd79692};
      2:       r = {21'd878466, 21'd140331, 21'd29780};
      default: r = '0;
    endcase
    return r;
  endfunction

  // output matrix rows (signed Q.20)
  function automatic srow_t mat_out_row(input int i);
    srow_t r;
    unique case (i)
      0: begin
        r[0] = 22'sd1682702;
        r[1] = -22'sd556878;
        r[2] = -22'sd77249;
      end
      1: begin
        r[0] = -22'sd107039;
        r[1] = 22'sd1161959;
        r[2] = -22'sd6344;
      end
      2: begin
        r[0] = -22'sd3429;
        r[1] = -22'sd76294;
        r[2] = 22'sd1128289;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/aftm_enc_lane.sv =====
// One channel of the sRGB encode curve, ten pipeline stages.
// Depends on aftm_pkg (curve tables and constants).
module aftm_enc_lane #(
  parameter int FRAC_BITS      = aftm_pkg::FRAC_BITS_DEF,
  parameter int INPUT_INT_BITS = aftm_pkg::INPUT_INT_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_vld,
  input  logic [INPUT_INT_BITS+FRAC_BITS-1:0]           in_x,
  output logic                                          out_vld,
  output logic [aftm_pkg::enc_width(INPUT_INT_BITS)-1:0] out_enc
);
  import aftm_pkg::*;

  localparam int IW     = INPUT_INT_BITS + FRAC_BITS;
  localparam int XW     = INPUT_INT_BITS + IQ;
  localparam int D_IN   = IQ - FRAC_BITS;
  localparam int EBW    = $clog2(XW);
  localparam int KW     = $clog2(5 * XW);
  localparam int KKMAX  = 5 * (XW - 1) - KK_OFS;
  localparam int QSMAX  = KKMAX / 12;
  localparam int QSW    = $clog2(QSMAX + 1);
  localparam int FW     = XW - 6;
  localparam int PW     = IQ + 2;
  localparam int PSW    = PW + QSMAX - 4;
  localparam int EW     = enc_width(INPUT_INT_BITS);
  localparam int SVW    = 16;

  logic [ENC_STAGES-1:0] vld_r;

  // valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[ENC_STAGES-2:0], in_vld};
    end
  end
  assign out_vld = vld_r[ENC_STAGES-1];

  // align the input to Q.20
  logic [XW-1:0] x_al;
  generate
    if (D_IN >= 0) begin : g_up
      assign x_al = XW'(in_x) << D_IN;
    end else begin : g_dn
      assign x_al = XW'(in_x >> (-D_IN));
    end
  endgenerate

  // stage 1: linear segment
  logic [XW-1:0]  x1_r;
  logic           sm1_r;
  logic [SVW-1:0] sv1_r;
  logic [35:0]    svp_c;
  assign svp_c = {24'd0, x_al[11:0]} * 36'(ENC_SLOPE);
  always_ff @(posedge clk) begin
    x1_r  <= x_al;
    sm1_r <= (x_al < XW'(SMALL_X_LIM));
    sv1_r <= svp_c[35:IQ];
  end

  // stage 2: leading one
  logic [EBW-1:0] e_c;
  always_comb begin
    e_c = '0;
    for (int b = 0; b < XW; b++) begin
      if (x1_r[b]) e_c = EBW'(b);
    end
  end
  logic [XW-1:0]  x2_r;
  logic [EBW-1:0] e2_r;
  logic           sm2_r;
  logic [SVW-1:0] sv2_r;
  always_ff @(posedge clk) begin
    x2_r  <= x1_r;
    e2_r  <= e_c;
    sm2_r <= sm1_r;
    sv2_r <= sv1_r;
  end

  // stage 3: normalize, split exponent into octave shift and twelfth step
  logic [KW-1:0]   kk_c;
  logic [KW+7:0]   kkm_c;
  logic [QSW-1:0]  qs_c;
  logic [KW-1:0]   r_c;
  assign kk_c  = KW'({e2_r, 2'b00}) + KW'(e2_r) - KW'(KK_OFS);
  assign kkm_c = (KW+8)'(kk_c) * (KW+8)'(RECIP12);
  assign qs_c  = QSW'(kkm_c >> RECIP12_SH);
  assign r_c   = kk_c - KW'(qs_c) * KW'(12);
  logic [XW-1:0]  xn3_r;
  logic [QSW-1:0] qs3_r;
  logic [3:0]     r3_r;
  logic           sm3_r;
  logic [SVW-1:0] sv3_r;
  always_ff @(posedge clk) begin
    xn3_r <= x2_r << (EBW'(XW - 1) - e2_r);
    qs3_r <= qs_c;
    r3_r  <= r_c[3:0];
    sm3_r <= sm2_r;
    sv3_r <= sv2_r;
  end

  // stage 4: mantissa table knots
  logic [4:0]     j_c;
  assign j_c = xn3_r[XW-2 -: 5];
  logic [TW-1:0]  mj4_r;
  logic [TW-1:0]  df4_r;
  logic [FW-1:0]  fr4_r;
  logic [QSW-1:0] qs4_r;
  logic [3:0]     r4_r;
  logic           sm4_r;
  logic [SVW-1:0] sv4_r;
  always_ff @(posedge clk) begin
    mj4_r <= MANT_TAB[j_c];
    df4_r <= MANT_TAB[6'(j_c) + 6'd1] - MANT_TAB[j_c];
    fr4_r <= xn3_r[FW-1:0];
    qs4_r <= qs3_r;
    r4_r  <= r3_r;
    sm4_r <= sm3_r;
    sv4_r <= sv3_r;
  end

  // stage 5: interpolation product
  logic [TW+FW-1:0] pr5_r;
  logic [TW-1:0]    mj5_r;
  logic [QSW-1:0]   qs5_r;
  logic [3:0]       r5_r;
  logic             sm5_r;
  logic [SVW-1:0]   sv5_r;
  always_ff @(posedge clk) begin
    pr5_r <= (TW+FW)'(df4_r) * (TW+FW)'(fr4_r);
    mj5_r <= mj4_r;
    qs5_r <= qs4_r;
    r5_r  <= r4_r;
    sm5_r <= sm4_r;
    sv5_r <= sv4_r;
  end

  // stage 6: mantissa root and octave root
  logic [TW-1:0]  m6_r;
  logic [TW-1:0]  oct6_r;
  logic [QSW-1:0] qs6_r;
  logic           sm6_r;
  logic [SVW-1:0] sv6_r;
  always_ff @(posedge clk) begin
    m6_r   <= mj5_r + pr5_r[TW+FW-1:FW];
    oct6_r <= (r5_r < 4'(OCT_LEN)) ? OCT_TAB[r5_r] : '0;
    qs6_r  <= qs5_r;
    sm6_r  <= sm5_r;
    sv6_r  <= sv5_r;
  end

  // stage 7: combine roots
  logic [2*TW-1:0] pm_c;
  assign pm_c = (2*TW)'(oct6_r) * (2*TW)'(m6_r);
  logic [PW-1:0]  p7_r;
  logic [QSW-1:0] qs7_r;
  logic           sm7_r;
  logic [SVW-1:0] sv7_r;
  always_ff @(posedge clk) begin
    p7_r  <= pm_c[2*TW-1:IQ];
    qs7_r <= qs6_r;
    sm7_r <= sm6_r;
    sv7_r <= sv6_r;
  end

  // stage 8: apply octave shift, offset by four
  logic [PW+QSMAX-1:0] sh_c;
  assign sh_c = (PW+QSMAX)'(p7_r) << qs7_r;
  logic [PSW-1:0] ps8_r;
  logic           sm8_r;
  logic [SVW-1:0] sv8_r;
  always_ff @(posedge clk) begin
    ps8_r <= sh_c[PW+QSMAX-1:4];
    sm8_r <= sm7_r;
    sv8_r <= sv7_r;
  end

  // stage 9: gain
  logic [PSW+20:0] gp_c;
  assign gp_c = (PSW+21)'(ps8_r) * (PSW+21)'(ENC_GAIN);
  logic [EW-1:0]  g9_r;
  logic           sm9_r;
  logic [SVW-1:0] sv9_r;
  always_ff @(posedge clk) begin
    g9_r  <= gp_c[PSW+20:IQ];
    sm9_r <= sm8_r;
    sv9_r <= sv8_r;
  end

  // stage 10: offset, pick segment
  logic [EW-1:0] enc_r;
  always_ff @(posedge clk) begin
    if (sm9_r) begin
      enc_r <= EW'(sv9_r);
    end else if (g9_r > EW'(ENC_OFFSET)) begin
      enc_r <= g9_r - EW'(ENC_OFFSET);
    end else begin
      enc_r <= '0;
    end
  end
  assign out_enc = enc_r;

endmodule

// ===== src/aftm_fit_lane.sv =====
// One output channel of the input matrix followed by the rational fit.
// Depends on aftm_pkg; the fit division is a pipelined restoring divider.
module aftm_fit_lane #(
  parameter int INPUT_INT_BITS = aftm_pkg::INPUT_INT_BITS_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic                                                in_vld,
  input  logic [2:0][aftm_pkg::enc_width(INPUT_INT_BITS)-1:0] enc,
  input  aftm_pkg::urow_t                                     row,
  output logic                                                out_vld,
  output logic [aftm_pkg::QW-1:0]                             out_rrt
);
  import aftm_pkg::*;

  localparam int EW  = enc_width(INPUT_INT_BITS);
  localparam int MW  = TW + EW;
  localparam int VW  = EW + 1;
  localparam int AW  = 2 * VW + 1 - IQ;
  localparam int BW  = AW + 1;
  localparam int RW  = AW + IQ + 2;

  logic [FIT_PRE_STAGES-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[FIT_PRE_STAGES-2:0], in_vld};
    end
  end

  // stage 1: matrix row products
  logic [2:0][MW-1:0] pm1_r;
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) pm1_r[k] <= MW'(row[k]) * MW'(enc[k]);
  end

  // stage 2: row sum back to Q.20
  logic [MW+1:0] sum_c;
  assign sum_c = (MW+2)'(pm1_r[0]) + (MW+2)'(pm1_r[1]) + (MW+2)'(pm1_r[2]);
  logic [VW-1:0] v2_r;
  always_ff @(posedge clk) begin
    v2_r <= VW'(sum_c >> IQ);
  end

  // stage 3: numerator and inner denominator term
  logic [2*VW:0]  ap_c;
  logic [VW+20:0] tp_c;
  assign ap_c = (2*VW+1)'(v2_r) * ((2*VW+1)'(v2_r) + (2*VW+1)'(FIT_A));
  assign tp_c = (VW+21)'(v2_r) * (VW+21)'(FIT_B2);
  logic [AW-1:0] a3_r;
  logic [VW:0]   t3_r;
  logic [VW-1:0] v3_r;
  always_ff @(posedge clk) begin
    a3_r <= ap_c[2*VW:IQ];
    t3_r <= (VW+1)'(tp_c >> IQ) + (VW+1)'(FIT_B1);
    v3_r <= v2_r;
  end

  // stage 4: denominator, numerator minus FIT_C clamped at zero
  logic [2*VW:0] bp_c;
  assign bp_c = (2*VW+1)'(v3_r) * (2*VW+1)'(t3_r);
  logic [BW-1:0] b4_r;
  logic [AW-1:0] an4_r;
  always_ff @(posedge clk) begin
    b4_r  <= BW'(bp_c[2*VW:IQ]) + BW'(FIT_B0);
    an4_r <= (a3_r > AW'(FIT_C)) ? a3_r - AW'(FIT_C) : '0;
  end

  // restoring divider, one quotient bit per stage
  logic [RW-1:0] rem_r [QW];
  logic [BW-1:0] bd_r  [QW];
  logic [QW-1:0] qt_r  [QW];
  logic [QW-1:0] dv_r;

  genvar g;
  generate
    for (g = 0; g < QW; g++) begin : g_div
      logic [RW-1:0] rem_in;
      logic [BW-1:0] b_in;
      logic [QW-1:0] q_in;
      logic          v_in;
      logic [RW-1:0] cand;
      if (g == 0) begin : g_first
        assign rem_in = RW'(an4_r) << IQ;
        assign b_in   = b4_r;
        assign q_in   = '0;
        assign v_in   = vld_r[FIT_PRE_STAGES-1];
      end else begin : g_next
        assign rem_in = rem_r[g-1];
        assign b_in   = bd_r[g-1];
        assign q_in   = qt_r[g-1];
        assign v_in   = dv_r[g-1];
      end
      assign cand = RW'(b_in) << (QW - 1 - g);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dv_r[g] <= 1'b0;
        end else begin
          dv_r[g] <= v_in;
        end
      end

      // subtract when the shifted divisor fits
      always_ff @(posedge clk) begin
        bd_r[g] <= b_in;
        if (rem_in >= cand) begin
          rem_r[g] <= rem_in - cand;
          qt_r[g]  <= q_in | (QW'(1) << (QW - 1 - g));
        end else begin
          rem_r[g] <= rem_in;
          qt_r[g]  <= q_in;
        end
      end
    end
  endgenerate

  assign out_vld = dv_r[QW-1];
  assign out_rrt = qt_r[QW-1];

endmodule

// ===== src/aftm_out_lane.sv =====
// Merge stage for one channel: output matrix over the three fit lanes,
// clamp and sRGB decode. Depends on aftm_pkg (decode table, matrix rows).
module aftm_out_lane #(
  parameter int FRAC_BITS = aftm_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [2:0][aftm_pkg::QW-1:0]  rrt,
  input  aftm_pkg::srow_t               row,
  output logic                          out_vld,
  output logic [FRAC_BITS:0]            out_y
);
  import aftm_pkg::*;

  localparam int PMW  = TW + QW + 2;
  localparam int D_IN = IQ - FRAC_BITS;
  localparam int OW   = FRAC_BITS + 1;
  localparam int SW   = PMW + 2 - IQ;

  logic [OUT_STAGES-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[OUT_STAGES-2:0], in_vld};
    end
  end
  assign out_vld = vld_r[OUT_STAGES-1];

  // stage 1: signed row products
  logic signed [2:0][PMW-1:0] sp1_r;
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) sp1_r[k] <= $signed(row[k]) * $signed({1'b0, rrt[k]});
  end

  // stage 2: sum and clamp to [0,1]
  logic signed [PMW+1:0] s_c;
  logic [SW-1:0]         tt_c;
  assign s_c  = $signed(sp1_r[0]) + $signed(sp1_r[1]) + $signed(sp1_r[2]);
  assign tt_c = s_c[PMW+1:IQ];
  logic [TW-1:0] t2_r;
  always_ff @(posedge clk) begin
    if (s_c <= 0) begin
      t2_r <= '0;
    end else if (tt_c > SW'(1 << IQ)) begin
      t2_r <= TW'(1 << IQ);
    end else begin
      t2_r <= TW'(tt_c);
    end
  end

  // stage 3: decode table knots and linear segment
  logic [TW+16:0] dsp_c;
  logic [8:0]     idx_c;
  logic [7:0]     lo_c;
  assign dsp_c = (TW+17)'(t2_r) * (TW+17)'(DEC_SLOPE);
  assign idx_c = t2_r[TW-1:12];
  assign lo_c  = idx_c[7:0];
  logic [TW-1:0] yj3_r;
  logic [TW-1:0] df3_r;
  logic [11:0]   fr3_r;
  logic          sm3_r;
  logic [TW-1:0] sv3_r;
  always_ff @(posedge clk) begin
    if (idx_c[8]) begin
      yj3_r <= DEC_TAB[256];
      df3_r <= '0;
    end else begin
      yj3_r <= DEC_TAB[{1'b0, lo_c}];
      df3_r <= DEC_TAB[9'(lo_c) + 9'd1] - DEC_TAB[{1'b0, lo_c}];
    end
    fr3_r <= t2_r[11:0];
    sm3_r <= (t2_r < TW'(DEC_LIM));
    sv3_r <= TW'(dsp_c >> IQ);
  end

  // stage 4: interpolation product
  logic [TW+11:0] pr4_r;
  logic [TW-1:0]  yj4_r;
  logic           sm4_r;
  logic [TW-1:0]  sv4_r;
  always_ff @(posedge clk) begin
    pr4_r <= (TW+12)'(df3_r) * (TW+12)'(fr3_r);
    yj4_r <= yj3_r;
    sm4_r <= sm3_r;
    sv4_r <= sv3_r;
  end

  // stage 5: finish, clamp to one, rescale to the output format
  logic [TW:0]   yi_c;
  logic [TW-1:0] y_c;
  logic [OW-1:0] o_c;
  assign yi_c = (TW+1)'(yj4_r) + (TW+1)'(pr4_r[TW+11:12]);
  always_comb begin
    if (sm4_r) begin
      y_c = sv4_r;
    end else if (yi_c > (TW+1)'(1 << IQ)) begin
      y_c = TW'(1 << IQ);
    end else begin
      y_c = TW'(yi_c);
    end
  end
  generate
    if (D_IN >= 0) begin : g_dn
      assign o_c = OW'(y_c >> D_IN);
    end else begin : g_up
      assign o_c = OW'(y_c) << (-D_IN);
    end
  endgenerate

  logic [OW-1:0] y5_r;
  always_ff @(posedge clk) begin
    y5_r <= o_c;
  end
  assign out_y = y5_r;

endmodule

// ===== src/aces_fitted_tone_map_top.sv =====
// ACES fitted tone map: three encode lanes, three fit lanes, three merge lanes.
// The path from an accepted request to out_valid runs through 10 encode, 4 fit
// setup, 21 divider and 5 merge/decode stages; one pixel is accepted every cycle.
// busy stays low: every pipeline stage advances each cycle, so the receiver
// takes each result in the single cycle that out_valid marks.
// Synchronous active-low reset clears all valid flags; data registers are not reset.
module aces_fitted_tone_map_top #(
  parameter int FRAC_BITS      = aftm_pkg::FRAC_BITS_DEF,
  parameter int INPUT_INT_BITS = aftm_pkg::INPUT_INT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [INPUT_INT_BITS+FRAC_BITS-1:0] in_red,
  input  logic [INPUT_INT_BITS+FRAC_BITS-1:0] in_green,
  input  logic [INPUT_INT_BITS+FRAC_BITS-1:0] in_blue,
  output logic                                out_valid,
  output logic [FRAC_BITS:0]                  out_red,
  output logic [FRAC_BITS:0]                  out_green,
  output logic [FRAC_BITS:0]                  out_blue
);
  import aftm_pkg::*;

  localparam int IW = INPUT_INT_BITS + FRAC_BITS;
  localparam int EW = enc_width(INPUT_INT_BITS);

  logic [2:0][IW-1:0]    pix;
  logic [2:0][EW-1:0]    enc;
  logic [2:0][QW-1:0]    rrt;
  logic [2:0][FRAC_BITS:0] res;
  logic [2:0]            enc_vld;
  logic [2:0]            fit_vld;
  logic [2:0]            out_vld;

  assign busy   = 1'b0;
  assign pix[0] = in_red;
  assign pix[1] = in_green;
  assign pix[2] = in_blue;

  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_lane
      // encode one channel
      aftm_enc_lane #(
        .FRAC_BITS      (FRAC_BITS),
        .INPUT_INT_BITS (INPUT_INT_BITS)
      ) u_enc (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (start),
        .in_x    (pix[g]),
        .out_vld (enc_vld[g]),
        .out_enc (enc[g])
      );

      // input matrix row and fit
      aftm_fit_lane #(
        .INPUT_INT_BITS (INPUT_INT_BITS)
      ) u_fit (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (&enc_vld),
        .enc     (enc),
        .row     (mat_in_row(g)),
        .out_vld (fit_vld[g]),
        .out_rrt (rrt[g])
      );

      // merge the three fit results for this channel
      aftm_out_lane #(
        .FRAC_BITS (FRAC_BITS)
      ) u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (&fit_vld),
        .rrt     (rrt),
        .row     (mat_out_row(g)),
        .out_vld (out_vld[g]),
        .out_y   (res[g])
      );
    end
  endgenerate

  assign out_valid = &out_vld;
  assign out_red   = res[0];
  assign out_green = res[1];
  assign out_blue  = res[2];

endmodule

// ===== src/aftm_checker.sv =====
// Port-level checks for the ACES fitted tone map top level, with its bind.
// Depends on aftm_pkg and the assertion macros header.
`include "aces_fitted_tone_map_top_defines.svh"

module aftm_checker #(
  parameter int FRAC_BITS      = aftm_pkg::FRAC_BITS_DEF,
  parameter int INPUT_INT_BITS = aftm_pkg::INPUT_INT_BITS_DEF
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic [INPUT_INT_BITS+FRAC_BITS-1:0] in_red,
  input logic [INPUT_INT_BITS+FRAC_BITS-1:0] in_green,
  input logic [INPUT_INT_BITS+FRAC_BITS-1:0] in_blue,
  input logic                                out_valid,
  input logic [FRAC_BITS:0]                  out_red,
  input logic [FRAC_BITS:0]                  out_green,
  input logic [FRAC_BITS:0]                  out_blue
);
  import aftm_pkg::*;

  logic [FRAC_BITS:0] one_c;
  logic               in_any_c;
  assign one_c    = (FRAC_BITS+1)'(1) << FRAC_BITS;
  assign in_any_c = |{in_red, in_green, in_blue} || !(|{in_red, in_green, in_blue});

  // the pipeline never pushes back
  `AFTM_ASSERT_IMP(busy_low_a, in_any_c, !busy, "busy raised")
  // every accepted request produces a result after the fixed latency
  `AFTM_ASSERT_DLY(result_due_a, start && !busy, LATENCY, out_valid, "result missing")
  // no result without a request the fixed latency earlier
  `AFTM_ASSERT_IMP(no_stray_a, out_valid, $past(start && !busy, LATENCY), "stray result")
  // results stay within [0,1]
  `AFTM_ASSERT_IMP(range_a, out_valid, (out_red <= one_c) && (out_green <= one_c) && (out_blue <= one_c), "result above one")

endmodule

bind aces_fitted_tone_map_top aftm_checker #(
  .FRAC_BITS      (FRAC_BITS),
  .INPUT_INT_BITS (INPUT_INT_BITS)
) u_aftm_checker (.*);
